@@ sv/pps_pkg.sv @@
package pps_pkg;

  localparam int HEAP_DEPTH = 32;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;
  localparam logic KIND_DONE   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arr;
    logic [15:0] rem;
    logic [7:0]  pri;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_SCAN_W,
    ST_SH_RD,
    ST_SH_WR,
    ST_POP,
    ST_PLACE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic emit_finish;
    logic scan;
    logic sh_rd;
    logic sh_wr;
    logic pop;
    logic place;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic run_busy;
    logic due;
    logic empty;
    logic drain;
    logic scan_end;
    logic sh_end;
  } sts_t;

endpackage

@@ sv/pps_ram.sv @@
module pps_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pps_ctrl.sv @@
module pps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pps_pkg::sts_t sts,
  output pps_pkg::cmd_t cmd
);
  import pps_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_CHK;
      ST_CHK: begin
        if (sts.run_busy && (sts.drain || sts.due)) begin
          state_nxt = sts.empty ? ST_CHK : ST_SCAN;
        end else begin
          state_nxt = sts.drain ? ST_FLUSH : ST_PLACE;
        end
      end
      ST_SCAN:   if (sts.scan_end) state_nxt = ST_SCAN_W;
      ST_SCAN_W: state_nxt = ST_SH_RD;
      ST_SH_RD:  state_nxt = sts.sh_end ? ST_POP : ST_SH_WR;
      ST_SH_WR:  state_nxt = ST_SH_RD;
      ST_POP:    state_nxt = ST_CHK;
      ST_PLACE:  state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.latch_in = start;
      ST_CHK:   cmd.emit_finish = sts.run_busy && (sts.drain || sts.due);
      ST_SCAN:  cmd.scan = 1'b1;
      ST_SH_RD: cmd.sh_rd = !sts.sh_end;
      ST_SH_WR: cmd.sh_wr = 1'b1;
      ST_POP:   cmd.pop = 1'b1;
      ST_PLACE: cmd.place = 1'b1;
      ST_FLUSH: cmd.flush = 1'b1;
      default:  cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ sv/pps_dp.sv @@
module pps_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  pps_pkg::cmd_t cmd,
  output pps_pkg::sts_t sts,
  input  logic          in_opcode,
  input  logic [15:0]   in_job_id,
  input  logic [31:0]   in_arrive_time,
  input  logic [15:0]   in_run_length,
  input  logic [7:0]    in_job_priority,
  output logic          out_valid,
  output logic          out_kind,
  output logic [15:0]   out_done_id,
  output logic [31:0]   out_finish_time,
  output logic          out_last
);
  import pps_pkg::*;

  logic              run_busy_r;
  job_t              run_r;
  logic [31:0]       run_start_r, run_end_r;
  logic [CW-1:0]     count_r;
  logic              op_r;
  job_t              in_r;
  logic [31:0]       t_r;
  logic [AW-1:0]     idx_r, cmp_idx_r, sh_r;
  logic              dv_r;
  job_t              best_r;
  logic              pend_v_r, pend_kind_r;
  logic [15:0]       pend_id_r;
  logic [31:0]       pend_time_r;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  job_t              wdata, rd;
  logic              better, full, preempt;
  logic [31:0]       elapsed, pop_start;
  logic [15:0]       pre_rem;
  logic              emit;
  logic              emit_kind;
  logic [15:0]       emit_id;
  logic [31:0]       emit_time;

  pps_ram #(.W(JOB_W), .D(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  assign full    = (count_r >= CW'(HEAP_DEPTH));
  assign preempt = (in_r.pri > run_r.pri);
  assign better  = dv_r && ((cmp_idx_r == '0) || (rd.pri > best_r.pri) ||
                   ((rd.pri == best_r.pri) && (rd.arr < best_r.arr)));
  assign elapsed = (in_r.arr >= run_start_r) ? (in_r.arr - run_start_r) : 32'd0;
  assign pre_rem = (elapsed < {16'd0, run_r.rem}) ? (run_r.rem - elapsed[15:0]) : 16'd0;
  assign pop_start = (t_r > best_r.arr) ? t_r : best_r.arr;

  always_comb begin
    raddr = cmd.sh_rd ? AW'(sh_r + 1'b1) : idx_r;
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = in_r;
    if (cmd.sh_wr) begin
      we    = 1'b1;
      waddr = sh_r;
      wdata = rd;
    end else if (cmd.place && run_busy_r && !full) begin
      we = 1'b1;
      if (preempt) begin
        wdata     = run_r;
        wdata.rem = pre_rem;
      end
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_DONE;
    emit_id   = run_r.id;
    emit_time = run_end_r;
    if (cmd.emit_finish) begin
      emit = 1'b1;
    end else if (cmd.place && run_busy_r && full) begin
      emit      = 1'b1;
      emit_kind = KIND_REJECT;
      emit_id   = in_r.id;
      emit_time = 32'd0;
    end
  end

  assign sts.run_busy = run_busy_r;
  assign sts.due      = (run_end_r <= in_r.arr);
  assign sts.empty    = (count_r == '0);
  assign sts.drain    = (op_r == OP_DRAIN);
  assign sts.scan_end = ({1'b0, idx_r} == CW'(count_r - 1'b1));
  assign sts.sh_end   = ({1'b0, sh_r} + 1'b1 >= count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_busy_r  <= 1'b0;
      run_r       <= '0;
      run_start_r <= '0;
      run_end_r   <= '0;
      count_r     <= '0;
      dv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      dv_r      <= cmd.scan;
      if (cmd.latch_in) begin
        op_r <= in_opcode;
        in_r <= '{id: in_job_id, arr: in_arrive_time, rem: in_run_length,
                  pri: in_job_priority};
      end
      if (emit) begin
        // previous result is known not to be the final one
        if (pend_v_r) begin
          out_valid       <= 1'b1;
          out_kind        <= pend_kind_r;
          out_done_id     <= pend_id_r;
          out_finish_time <= pend_time_r;
          out_last        <= 1'b0;
        end
        pend_v_r    <= 1'b1;
        pend_kind_r <= emit_kind;
        pend_id_r   <= emit_id;
        pend_time_r <= emit_time;
      end
      if (cmd.emit_finish) begin
        t_r   <= run_end_r;
        idx_r <= '0;
        if (count_r == '0) run_busy_r <= 1'b0;
      end
      if (cmd.scan) idx_r <= idx_r + 1'b1;
      cmp_idx_r <= idx_r;
      if (better) begin
        best_r <= rd;
        sh_r   <= cmp_idx_r;
      end
      if (cmd.sh_wr) sh_r <= sh_r + 1'b1;
      if (cmd.pop) begin
        count_r     <= count_r - 1'b1;
        run_busy_r  <= 1'b1;
        run_r       <= best_r;
        run_start_r <= pop_start;
        run_end_r   <= pop_start + {16'd0, best_r.rem};
      end
      if (cmd.place) begin
        if (!run_busy_r || (!full && preempt)) begin
          run_busy_r  <= 1'b1;
          run_r       <= in_r;
          run_start_r <= in_r.arr;
          run_end_r   <= in_r.arr + {16'd0, in_r.rem};
        end
        if (run_busy_r && !full) count_r <= count_r + 1'b1;
      end
      if (cmd.flush && pend_v_r) begin
        out_valid       <= 1'b1;
        out_kind        <= pend_kind_r;
        out_done_id     <= pend_id_r;
        out_finish_time <= pend_time_r;
        out_last        <= 1'b1;
        pend_v_r        <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH)) else $error("heap count overflow");
  a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(pend_v_r)) else $error("result without pending entry");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REJECT |-> out_finish_time == 32'd0)
    else $error("reject with nonzero time");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0) else $error("pop from empty heap");
`endif

endmodule

@@ sv/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler for one processor. Pulse start while busy is low to transfer
// one item (arrival or drain); results come one per out_valid pulse and cannot be stalled,
// out_last marks the final result of an item. Each item keeps busy high until it is handled;
// per finished job with a non-empty ready store, this includes a scan of the N-entry ready
// store through its single RAM read port and a compaction of the entries behind the chosen
// one; the ready store RAM needs no clearing after reset.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [15:0] in_job_id,
  input  logic [31:0] in_arrive_time,
  input  logic [15:0] in_run_length,
  input  logic [7:0]  in_job_priority,
  output logic        out_valid,
  output logic        out_kind,
  output logic [15:0] out_done_id,
  output logic [31:0] out_finish_time,
  output logic        out_last
);
  import pps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  pps_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_opcode), .in_job_id(in_job_id), .in_arrive_time(in_arrive_time),
    .in_run_length(in_run_length), .in_job_priority(in_job_priority),
    .out_valid(out_valid), .out_kind(out_kind), .out_done_id(out_done_id),
    .out_finish_time(out_finish_time), .out_last(out_last)
  );

endmodule
